FILE: sv/kft_pkg.sv
package kft_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_OP,
    ST_DIV,
    ST_GAIN,
    ST_WB,
    ST_OUT
  } st_t;

  // multiply-accumulate steps, in issue order
  typedef enum logic [4:0] {
    OP_XP0, OP_XP1,
    OP_AP00, OP_AP01, OP_AP10, OP_AP11,
    OP_PP00, OP_PP01, OP_PP10, OP_PP11,
    OP_HP0, OP_HP1,
    OP_DEN, OP_Y,
    OP_X0, OP_X1,
    OP_M00, OP_M01, OP_M10, OP_M11,
    OP_NP00, OP_NP01, OP_NP10, OP_NP11
  } op_t;

  // configuration register indexes
  localparam logic [2:0] REG_TRANS0 = 3'd0;
  localparam logic [2:0] REG_TRANS1 = 3'd1;
  localparam logic [2:0] REG_NOISE0 = 3'd2;
  localparam logic [2:0] REG_NOISE1 = 3'd3;
  localparam logic [2:0] REG_MEAS   = 3'd4;
  localparam logic [2:0] REG_RNOISE = 3'd5;

  localparam logic [31:0] TRANS0_RST = 32'h0100_0100;
  localparam logic [31:0] TRANS1_RST = 32'h0000_0100;
  localparam logic [31:0] MEAS_RST   = 32'h0100_0000;
  localparam logic [15:0] RNOISE_RST = 16'h0100;

  localparam logic signed [31:0] P_DIAG_RST = 32'sd6553600;  // 100.0 in Q16.16
  localparam logic signed [65:0] ONE_Q24    = 66'sd16777216;

  localparam int DIV_STEPS = 56;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] rnd8(input logic signed [65:0] v);
    return (v + 66'sd128) >>> 8;
  endfunction

  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    return (v + 66'sd32768) >>> 16;
  endfunction

endpackage

FILE: sv/kalman_filter_two_state.sv
// Channel  Dir  Handshake         Beat contents
// in       in   in_valid/in_stall  in_channel, in_measurement
// out      out  out_valid/out_stall out_channel_out, out_rounded_estimate,
//                                  out_position_estimate, out_rate_estimate
// cfg      in   cfg_we            cfg_index, cfg_wdata
//
// One beat reads the channel state, runs 24 multiply steps on the one shared
// 32x32 multiplier and a 56-step restoring divider (both gains side by side),
// then writes the channel state back and moves the result to the output.
// Reset (rst_n low, synchronous) restores the registers and marks every
// channel's stored state as reset; no clearing pass runs.
// in_stall is high while a beat is in work; the result waits in the output
// register under out_stall, and the next input beat can already be taken.
module kalman_filter_two_state
  import kft_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_channel,
  input  logic [7:0]         in_measurement,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_channel_out,
  output logic [7:0]         out_rounded_estimate,
  output logic signed [31:0] out_position_estimate,
  output logic signed [31:0] out_rate_estimate,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PA_W = $clog2(CHANNELS * 4);
  localparam int XA_W = $clog2(CHANNELS * 2);

  // configuration
  logic [31:0] trans0_r, trans1_r, noise0_r, noise1_r, meas_r;
  logic [15:0] rnoise_r;

  // sequencer
  st_t        state_r, state_nxt;
  op_t        op_r;
  logic [1:0] phase_r;
  logic [5:0] cnt_r;
  logic [CHANNELS-1:0] vld_r;

  // item context
  logic            chan_r;
  logic [CH_W-1:0] ch_r;
  logic [7:0]      z_r;

  // state memories, one entry per element per channel
  logic signed [31:0] p_mem [CHANNELS*4];
  logic signed [31:0] x_mem [CHANNELS*2];
  logic signed [31:0] p_rd_r, x_rd_r;
  logic [PA_W-1:0]    p_addr;
  logic [XA_W-1:0]    x_addr;
  logic               mem_we;

  // working set
  logic signed [31:0] xw_r [2];
  logic signed [31:0] pw_r [4];
  logic signed [31:0] xp_r [2];
  logic signed [31:0] ap_r [4];
  logic signed [31:0] pp_r [4];
  logic signed [31:0] hp_r [2];
  logic signed [31:0] k_r  [2];
  logic signed [31:0] m_r  [4];
  logic signed [31:0] y_r;
  logic signed [63:0] den_r;

  // multiply-accumulate datapath
  logic signed [31:0] a00, a01, a10, a11, h0, h1;
  logic signed [65:0] q00, q01, q10, q11;
  logic signed [31:0] op_a0, op_b0, op_a1, op_b1, mul_a, mul_b;
  logic signed [65:0] bias;
  logic               use_rnd8, prod_rnd, prod_neg;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, term, sum, res;
  logic signed [31:0] res32;

  // divider lanes
  logic [55:0] dvd_r [2];
  logic [63:0] rem_r [2];
  logic [63:0] dvs_r;
  logic [63:0] rem_sh [2];
  logic [63:0] den_abs;
  logic [31:0] hp_abs [2];
  logic signed [31:0] gain [2];

  logic signed [32:0] rnd_pos;
  logic [7:0]         rnd_byte;
  logic [1:0]         ld_idx;
  logic               in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // -------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans0_r <= TRANS0_RST;
      trans1_r <= TRANS1_RST;
      noise0_r <= '0;
      noise1_r <= '0;
      meas_r   <= MEAS_RST;
      rnoise_r <= RNOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRANS0: trans0_r <= cfg_wdata;
        REG_TRANS1: trans1_r <= cfg_wdata;
        REG_NOISE0: noise0_r <= cfg_wdata;
        REG_NOISE1: noise1_r <= cfg_wdata;
        REG_MEAS:   meas_r   <= cfg_wdata;
        REG_RNOISE: rnoise_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Q8.8 coefficients widened to multiplier operands
  assign a00 = {{16{trans0_r[31]}}, trans0_r[31:16]};
  assign a01 = {{16{trans0_r[15]}}, trans0_r[15:0]};
  assign a10 = {{16{trans1_r[31]}}, trans1_r[31:16]};
  assign a11 = {{16{trans1_r[15]}}, trans1_r[15:0]};
  assign h0  = {{16{meas_r[31]}}, meas_r[31:16]};
  assign h1  = {{16{meas_r[15]}}, meas_r[15:0]};
  // Q entries lifted to Q24.24
  assign q00 = {{34{noise0_r[31]}}, noise0_r[31:16], 16'd0};
  assign q01 = {{34{noise0_r[15]}}, noise0_r[15:0], 16'd0};
  assign q10 = {{34{noise1_r[31]}}, noise1_r[31:16], 16'd0};
  assign q11 = {{34{noise1_r[15]}}, noise1_r[15:0], 16'd0};

  // -------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOAD;
      ST_LOAD: if (cnt_r == 6'd4) state_nxt = ST_OP;
      ST_OP: begin
        if (phase_r == 2'd2) begin
          if (op_r == OP_Y) begin
            state_nxt = ST_DIV;
          end else if (op_r == OP_NP11) begin
            state_nxt = ST_WB;
          end
        end
      end
      ST_DIV:  if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = ST_OP;
      ST_WB:   if (cnt_r == 6'd3) state_nxt = ST_OUT;
      ST_OUT:  if (!(out_valid && out_stall)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // step counters and per-channel written marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_XP0;
      phase_r <= '0;
      cnt_r   <= '0;
      vld_r   <= '0;
    end else begin
      if (state_r != state_nxt) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
      if (state_r == ST_LOAD) begin
        op_r    <= OP_XP0;
        phase_r <= '0;
      end else if (state_r == ST_GAIN) begin
        op_r    <= OP_X0;
        phase_r <= '0;
      end else if (state_r == ST_OP) begin
        if (phase_r == 2'd2) begin
          phase_r <= '0;
          op_r    <= op_t'(op_r + 5'd1);
        end else begin
          phase_r <= phase_r + 2'd1;
        end
      end
      if (state_r == ST_WB && cnt_r == 6'd3) begin
        vld_r[ch_r] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------
  // State memories: read in LOAD, written back in WB
  // -------------------------------------------------------------------
  assign p_addr = PA_W'({ch_r, cnt_r[1:0]});
  assign x_addr = XA_W'({ch_r, cnt_r[0]});
  assign mem_we = (state_r == ST_WB);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      p_mem[p_addr] <= pw_r[cnt_r[1:0]];
      if (!cnt_r[1]) begin
        x_mem[x_addr] <= xw_r[cnt_r[0]];
      end
    end
    p_rd_r <= p_mem[p_addr];
    x_rd_r <= x_mem[x_addr];
  end

  // -------------------------------------------------------------------
  // Step operands: up to two products, a bias and rounding options
  // -------------------------------------------------------------------
  always_comb begin
    op_a0    = '0;
    op_b0    = '0;
    op_a1    = '0;
    op_b1    = '0;
    bias     = '0;
    use_rnd8 = 1'b1;
    prod_rnd = 1'b0;
    prod_neg = 1'b0;
    unique case (op_r)
      OP_XP0:  begin op_a0 = a00; op_b0 = xw_r[0]; op_a1 = a01; op_b1 = xw_r[1]; end
      OP_XP1:  begin op_a0 = a10; op_b0 = xw_r[0]; op_a1 = a11; op_b1 = xw_r[1]; end
      OP_AP00: begin op_a0 = a00; op_b0 = pw_r[0]; op_a1 = a01; op_b1 = pw_r[2]; end
      OP_AP01: begin op_a0 = a00; op_b0 = pw_r[1]; op_a1 = a01; op_b1 = pw_r[3]; end
      OP_AP10: begin op_a0 = a10; op_b0 = pw_r[0]; op_a1 = a11; op_b1 = pw_r[2]; end
      OP_AP11: begin op_a0 = a10; op_b0 = pw_r[1]; op_a1 = a11; op_b1 = pw_r[3]; end
      OP_PP00: begin
        op_a0 = ap_r[0]; op_b0 = a00; op_a1 = ap_r[1]; op_b1 = a01; bias = q00;
      end
      OP_PP01: begin
        op_a0 = ap_r[0]; op_b0 = a10; op_a1 = ap_r[1]; op_b1 = a11; bias = q01;
      end
      OP_PP10: begin
        op_a0 = ap_r[2]; op_b0 = a00; op_a1 = ap_r[3]; op_b1 = a01; bias = q10;
      end
      OP_PP11: begin
        op_a0 = ap_r[2]; op_b0 = a10; op_a1 = ap_r[3]; op_b1 = a11; bias = q11;
      end
      OP_HP0:  begin op_a0 = pp_r[0]; op_b0 = h0; op_a1 = pp_r[1]; op_b1 = h1; end
      OP_HP1:  begin op_a0 = pp_r[2]; op_b0 = h0; op_a1 = pp_r[3]; op_b1 = h1; end
      OP_DEN: begin
        op_a0 = h0; op_b0 = hp_r[0]; op_a1 = h1; op_b1 = hp_r[1];
        bias = {34'd0, rnoise_r, 16'd0};
        use_rnd8 = 1'b0;
      end
      OP_Y:    begin op_a0 = h0; op_b0 = xp_r[0]; op_a1 = h1; op_b1 = xp_r[1]; end
      OP_X0: begin
        op_a0 = k_r[0]; op_b0 = y_r; bias = 66'(xp_r[0]);
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      OP_X1: begin
        op_a0 = k_r[1]; op_b0 = y_r; bias = 66'(xp_r[1]);
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      OP_M00: begin op_a0 = k_r[0]; op_b0 = h0; prod_neg = 1'b1; bias = ONE_Q24; end
      OP_M01: begin op_a0 = k_r[0]; op_b0 = h1; prod_neg = 1'b1; end
      OP_M10: begin op_a0 = k_r[1]; op_b0 = h0; prod_neg = 1'b1; end
      OP_M11: begin op_a0 = k_r[1]; op_b0 = h1; prod_neg = 1'b1; bias = ONE_Q24; end
      OP_NP00: begin
        op_a0 = m_r[0]; op_b0 = pp_r[0]; op_a1 = m_r[1]; op_b1 = pp_r[2];
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      OP_NP01: begin
        op_a0 = m_r[0]; op_b0 = pp_r[1]; op_a1 = m_r[1]; op_b1 = pp_r[3];
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      OP_NP10: begin
        op_a0 = m_r[2]; op_b0 = pp_r[0]; op_a1 = m_r[3]; op_b1 = pp_r[2];
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      OP_NP11: begin
        op_a0 = m_r[2]; op_b0 = pp_r[1]; op_a1 = m_r[3]; op_b1 = pp_r[3];
        prod_rnd = 1'b1; use_rnd8 = 1'b0;
      end
      default: ;
    endcase
  end

  // phase 0 multiplies the first pair, phase 1 the second
  assign mul_a = (phase_r == 2'd0) ? op_a0 : op_a1;
  assign mul_b = (phase_r == 2'd0) ? op_b0 : op_b1;

  always_comb begin
    term = prod_rnd ? rnd16(66'(prod_r)) : 66'(prod_r);
    if (prod_neg) begin
      term = -term;
    end
    sum   = acc_r + term + bias;
    res   = use_rnd8 ? rnd8(sum) : sum;
    res32 = sat32(res);
  end

  // -------------------------------------------------------------------
  // Divider: |hp_i| * 2^24 / |den|, one quotient bit per cycle per lane
  // -------------------------------------------------------------------
  assign den_abs = den_r[63] ? (~den_r + 64'd1) : den_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hp_abs[i] = hp_r[i][31] ? (~hp_r[i] + 32'd1) : hp_r[i];
      rem_sh[i] = {rem_r[i][62:0], dvd_r[i][55]};
      if (dvs_r == 64'd0) begin
        gain[i] = '0;
      end else if (hp_r[i][31] ^ den_r[63]) begin
        gain[i] = (dvd_r[i] > 56'h0000_0080_000_000) ? 32'sh8000_0000
                                                     : -dvd_r[i][31:0];
      end else begin
        gain[i] = (dvd_r[i] > 56'h0000_007F_FFF_FFF) ? 32'sh7FFF_FFFF
                                                     : dvd_r[i][31:0];
      end
    end
  end

  // -------------------------------------------------------------------
  // Datapath registers
  // -------------------------------------------------------------------
  assign ld_idx = cnt_r[1:0] - 2'd1;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r <= in_channel;
      ch_r   <= (CHANNELS > 1) ? CH_W'(in_channel) : '0;
      z_r    <= in_measurement;
    end

    // entries of a channel never written back read as the reset state
    if (state_r == ST_LOAD && cnt_r != 6'd0) begin
      if (vld_r[ch_r]) begin
        pw_r[ld_idx] <= p_rd_r;
      end else begin
        pw_r[ld_idx] <= (ld_idx == 2'd0 || ld_idx == 2'd3) ? P_DIAG_RST : '0;
      end
      if (!ld_idx[1]) begin
        xw_r[ld_idx[0]] <= vld_r[ch_r] ? x_rd_r : '0;
      end
    end

    if (state_r == ST_OP) begin
      if (phase_r != 2'd2) begin
        prod_r <= mul_a * mul_b;
      end
      if (phase_r == 2'd1) begin
        acc_r <= term;
      end
      if (phase_r == 2'd2) begin
        unique case (op_r)
          OP_XP0:  xp_r[0] <= res32;
          OP_XP1:  xp_r[1] <= res32;
          OP_AP00: ap_r[0] <= res32;
          OP_AP01: ap_r[1] <= res32;
          OP_AP10: ap_r[2] <= res32;
          OP_AP11: ap_r[3] <= res32;
          OP_PP00: pp_r[0] <= res32;
          OP_PP01: pp_r[1] <= res32;
          OP_PP10: pp_r[2] <= res32;
          OP_PP11: pp_r[3] <= res32;
          OP_HP0:  hp_r[0] <= res32;
          OP_HP1:  hp_r[1] <= res32;
          OP_DEN:  den_r   <= res[63:0];
          OP_Y: begin
            y_r <= sat32({42'd0, z_r, 16'd0} - res);
            for (int i = 0; i < 2; i++) begin
              dvd_r[i] <= {hp_abs[i], 24'd0};
              rem_r[i] <= '0;
            end
            dvs_r <= den_abs;
          end
          OP_X0:   xw_r[0] <= res32;
          OP_X1:   xw_r[1] <= res32;
          OP_M00:  m_r[0]  <= res32;
          OP_M01:  m_r[1]  <= res32;
          OP_M10:  m_r[2]  <= res32;
          OP_M11:  m_r[3]  <= res32;
          OP_NP00: pw_r[0] <= res32;
          OP_NP01: pw_r[1] <= res32;
          OP_NP10: pw_r[2] <= res32;
          OP_NP11: pw_r[3] <= res32;
          default: ;
        endcase
      end
    end

    if (state_r == ST_DIV) begin
      for (int i = 0; i < 2; i++) begin
        if (rem_sh[i] >= dvs_r) begin
          rem_r[i] <= rem_sh[i] - dvs_r;
          dvd_r[i] <= {dvd_r[i][54:0], 1'b1};
        end else begin
          rem_r[i] <= rem_sh[i];
          dvd_r[i] <= {dvd_r[i][54:0], 1'b0};
        end
      end
    end

    if (state_r == ST_GAIN) begin
      k_r[0] <= gain[0];
      k_r[1] <= gain[1];
    end
  end

  // -------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------
  assign rnd_pos = ($signed({xw_r[0][31], xw_r[0]}) + 33'sd32768) >>> 16;
  always_comb begin
    if (rnd_pos[32]) begin
      rnd_byte = 8'd0;
    end else if (rnd_pos > 33'sd255) begin
      rnd_byte = 8'd255;
    end else begin
      rnd_byte = rnd_pos[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (state_r == ST_OUT && !(out_valid && out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && !(out_valid && out_stall)) begin
      out_channel_out       <= chan_r;
      out_rounded_estimate  <= rnd_byte;
      out_position_estimate <= xw_r[0];
      out_rate_estimate     <= xw_r[1];
    end
  end

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOAD && cnt_r == 6'd0)
    else $error("accepted beat did not start a state read");

  a_out_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !(out_valid && out_stall)) |=> out_valid && state_r == ST_IDLE)
    else $error("finished beat not moved to output");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GAIN && dvs_r == 64'd0) |=> k_r[0] == 32'sd0 && k_r[1] == 32'sd0)
    else $error("zero denominator gave nonzero gain");

  a_neg_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_position_estimate[31]) |-> out_rounded_estimate == 8'd0)
    else $error("negative estimate not clamped to zero");

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == 6'd0) |-> $past(op_r) == OP_Y)
    else $error("divider started out of sequence");
`endif

endmodule
